[rtl/core/ddarc_pkg.sv]
package ddarc_pkg;

    localparam int MAP_DIM_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 22;

    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_EYE_X         = 3'd2;
    localparam logic [CFG_IW-1:0] REG_EYE_Y         = 3'd3;
    localparam logic [CFG_IW-1:0] REG_VIEW_DIR_X    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_VIEW_DIR_Y    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_CAM_PLANE_X   = 3'd6;
    localparam logic [CFG_IW-1:0] REG_CAM_PLANE_Y   = 3'd7;

    localparam logic [12:0]        RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [12:0]        RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [21:0]        RST_EYE_X         = 22'd131072;
    localparam logic [21:0]        RST_EYE_Y         = 22'd131072;
    localparam logic signed [17:0] RST_VIEW_DIR_X    = -18'sd65536;
    localparam logic signed [17:0] RST_VIEW_DIR_Y    = 18'sd0;
    localparam logic signed [17:0] RST_CAM_PLANE_X   = 18'sd0;
    localparam logic signed [17:0] RST_CAM_PLANE_Y   = 18'sd43253;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;
    localparam logic ST_HIT   = 1'b0;
    localparam logic ST_OUT   = 1'b1;
    localparam logic SIDE_X   = 1'b0;
    localparam logic SIDE_Y   = 1'b1;

    localparam logic [7:0]  WALL_MARK = 8'h30;
    localparam logic [23:0] COLOR_X   = 24'hE1E87D;
    localparam logic [23:0] COLOR_Y   = 24'h79DBB8;
    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic [15:0] SAT16     = 16'hFFFF;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [7:0]  cell_value;
        logic [11:0] column;
    } item_t;

    typedef struct packed {
        logic [11:0] column_done;
        logic        status;
        logic        wall_side;
        logic [31:0] wall_distance;
        logic [15:0] line_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic [23:0] wall_color;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
    } result_t;

endpackage

[rtl/core/dda_ray_column_caster.sv]
// Casts one screen column at a time through a square map held in a block RAM.
// A write item stores one map cell, if its coordinates lie inside the map, and
// busy stays low. A cast item holds busy high until its result beat; the five
// divisions share one radix-2 divider that retires one quotient bit per cycle,
// and each walk step waits for one map RAM read.
// The result beat appears on res for the single cycle that done is high, in
// the cycle in which busy falls; the receiver cannot hold it off, so capture
// it then. Write configuration registers only while busy is low.
module dda_ray_column_caster
    import ddarc_pkg::*;
#(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             cmd,
    output logic              busy,
    output logic              done,
    output result_t           res,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_idx,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int MW   = $clog2(MAP_DIM);
    localparam int AW   = $clog2(MAP_DIM * MAP_DIM);
    localparam int PW   = MW + 2;
    localparam int CAMW = F + 15;
    localparam int RW   = 33;
    localparam int MA   = (F + 2 > 18) ? F + 2 : 18;
    localparam int MB   = (F + 15 > 33) ? F + 15 : 33;
    localparam int PRW  = MA + MB;
    localparam int DIVN = 2 * F + MW + 8;
    localparam int DIVD = 32;
    localparam int SDW  = MW + 36;
    localparam int NMW  = F + MW + 3;
    localparam int EWW  = F + 23;

    localparam logic [DIVN-1:0]        ONE_N   = DIVN'(64'd1 << F);
    localparam logic [DIVN-1:0]        ONE2_N  = DIVN'(64'd1 << (2 * F));
    localparam logic [F:0]             ONE_F   = (F+1)'(64'd1 << F);
    localparam logic signed [NMW-1:0]  ONE_S   = NMW'(64'd1 << F);
    localparam logic signed [PW-1:0]   DIM_S   = PW'(MAP_DIM);
    localparam logic [EWW-1:0]         DIM_E   = EWW'(MAP_DIM);
    localparam logic signed [PW-1:0]   STEP_P  = PW'(1);
    localparam logic [DIVN-1:0]        SAT32_N = DIVN'(SAT32);
    localparam logic [DIVN-1:0]        SAT16_N = DIVN'(SAT16);

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_CAM  = 16'b0000_0000_0000_0010,
        S_MULX = 16'b0000_0000_0000_0100,
        S_RAYX = 16'b0000_0000_0000_1000,
        S_MULY = 16'b0000_0000_0001_0000,
        S_RAYY = 16'b0000_0000_0010_0000,
        S_DELX = 16'b0000_0000_0100_0000,
        S_DELY = 16'b0000_0000_1000_0000,
        S_SDX  = 16'b0000_0001_0000_0000,
        S_SDY  = 16'b0000_0010_0000_0000,
        S_SEED = 16'b0000_0100_0000_0000,
        S_STEP = 16'b0000_1000_0000_0000,
        S_LOOK = 16'b0001_0000_0000_0000,
        S_DIST = 16'b0010_0000_0000_0000,
        S_LINE = 16'b0100_0000_0000_0000,
        S_FIN  = 16'b1000_0000_0000_0000
    } state_t;

    function automatic logic signed [RW-1:0] fix_trunc(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] s;
        logic                  adj;
        s   = p >>> F;
        adj = p[PRW-1] && (p[F-1:0] != '0);
        return RW'(s) + {{(RW-1){1'b0}}, adj};
    endfunction

    function automatic logic [31:0] sat32(input logic [DIVN-1:0] q);
        return (q > SAT32_N) ? SAT32 : q[31:0];
    endfunction

    logic [12:0]        width_reg, height_reg;
    logic [21:0]        eyex_reg, eyey_reg;
    logic signed [17:0] dirx_reg, diry_reg, plx_reg, ply_reg;

    state_t                 state_reg, state_next;
    logic                   div_run_reg, div_run_next;
    logic                   done_reg, done_next;
    logic [11:0]            col_reg, col_next;
    logic signed [CAMW-1:0] cam_reg, cam_next;
    logic signed [RW-1:0]   rx_reg, rx_next, ry_reg, ry_next;
    logic [31:0]            dx_reg, dx_next, dy_reg, dy_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;
    logic [SDW-1:0]         sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic signed [PW-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic                   side_reg, side_next;
    logic                   err_reg, err_next;
    logic [31:0]            dist_reg, dist_next;
    logic [15:0]            lh_reg, lh_next;
    result_t                res_reg, res_next;

    logic                   div_start, div_done;
    logic [DIVN-1:0]        div_num, div_quo;
    logic [DIVD-1:0]        div_den;
    logic signed [MA-1:0]   mul_a;
    logic signed [MB-1:0]   mul_b;
    logic signed [PRW-1:0]  mul_p;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [7:0]             ram_rdata;

    logic [12:0]            wd;
    logic [EWW-1:0]         eye_xw, eye_yw;
    logic [F:0]             fx, fy;
    logic signed [RW-1:0]   rx_neg, ry_neg;
    logic [31:0]            rx_abs, ry_abs;
    logic                   x_first;
    logic signed [PW-1:0]   nx, ny;
    logic                   walk_out;
    logic signed [NMW-1:0]  eye_sel, num_v;
    logic [NMW-1:0]         num_abs;
    logic [11:0]            hh, st;
    logic [14:0]            lh2;
    logic [16:0]            es, en17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            eyex_reg   <= RST_EYE_X;
            eyey_reg   <= RST_EYE_Y;
            dirx_reg   <= RST_VIEW_DIR_X;
            diry_reg   <= RST_VIEW_DIR_Y;
            plx_reg    <= RST_CAM_PLANE_X;
            ply_reg    <= RST_CAM_PLANE_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[12:0];
                REG_EYE_X:         eyex_reg   <= cfg_data[21:0];
                REG_EYE_Y:         eyey_reg   <= cfg_data[21:0];
                REG_VIEW_DIR_X:    dirx_reg   <= cfg_data[17:0];
                REG_VIEW_DIR_Y:    diry_reg   <= cfg_data[17:0];
                REG_CAM_PLANE_X:   plx_reg    <= cfg_data[17:0];
                REG_CAM_PLANE_Y:   ply_reg    <= cfg_data[17:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    assign ram_we    = start && (state_reg == S_IDLE) && (cmd.opcode == OP_WRITE)
                       && (32'(cmd.cell_x) < MAP_DIM) && (32'(cmd.cell_y) < MAP_DIM);
    assign ram_waddr = AW'(cmd.cell_x) * AW'(MAP_DIM) + AW'(cmd.cell_y);

    ddarc_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DIM * MAP_DIM)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.cell_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ddarc_div #(
        .NUM_W (DIVN),
        .DEN_W (DIVD)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    assign wd      = (width_reg == '0) ? 13'd1 : width_reg;
    assign eye_xw  = EWW'(eyex_reg);
    assign eye_yw  = EWW'(eyey_reg);
    assign fx      = rx_reg[RW-1] ? {1'b0, eye_xw[F-1:0]} : ONE_F - {1'b0, eye_xw[F-1:0]};
    assign fy      = ry_reg[RW-1] ? {1'b0, eye_yw[F-1:0]} : ONE_F - {1'b0, eye_yw[F-1:0]};
    assign rx_neg  = -rx_reg;
    assign ry_neg  = -ry_reg;
    assign rx_abs  = rx_reg[RW-1] ? rx_neg[31:0] : rx_reg[31:0];
    assign ry_abs  = ry_reg[RW-1] ? ry_neg[31:0] : ry_reg[31:0];
    assign x_first = sdx_reg < sdy_reg;
    assign nx      = !x_first ? mx_reg : (rx_reg[RW-1] ? mx_reg - STEP_P : mx_reg + STEP_P);
    assign ny      = x_first ? my_reg : (ry_reg[RW-1] ? my_reg - STEP_P : my_reg + STEP_P);
    assign walk_out = nx[PW-1] || (nx >= DIM_S) || ny[PW-1] || (ny >= DIM_S);
    assign ram_raddr = AW'(nx[MW-1:0]) * AW'(MAP_DIM) + AW'(ny[MW-1:0]);

    assign eye_sel = side_reg ? NMW'(eyey_reg) : NMW'(eyex_reg);
    assign num_v   = ((side_reg ? NMW'(my_reg) : NMW'(mx_reg)) <<< F) - eye_sel
                     + ((side_reg ? ry_reg[RW-1] : rx_reg[RW-1]) ? ONE_S : '0);
    assign num_abs = num_v[NMW-1] ? NMW'(-num_v) : NMW'(num_v);

    assign hh   = height_reg[12:1];
    assign lh2  = lh_reg[15:1];
    assign st   = (15'(hh) >= lh2) ? 12'(15'(hh) - lh2) : 12'd0;
    assign es   = 17'(hh) + 17'(lh2);
    assign en17 = (height_reg == '0) ? 17'd0 :
                  (es >= 17'(height_reg)) ? 17'(height_reg) - 17'd1 : es;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            S_CAM:
            begin
                div_num = DIVN'({col_reg, 1'b0}) << F;
                div_den = DIVD'(wd);
            end
            S_MULX:
            begin
                mul_a = MA'(plx_reg);
                mul_b = MB'(cam_reg);
            end
            S_MULY:
            begin
                mul_a = MA'(ply_reg);
                mul_b = MB'(cam_reg);
            end
            S_DELX:
            begin
                div_num = ONE2_N;
                div_den = rx_abs;
            end
            S_DELY:
            begin
                div_num = ONE2_N;
                div_den = ry_abs;
            end
            S_SDX:
            begin
                mul_a = MA'({1'b0, fx});
                mul_b = MB'({1'b0, dx_reg});
            end
            S_SDY:
            begin
                mul_a = MA'({1'b0, fy});
                mul_b = MB'({1'b0, dy_reg});
            end
            S_DIST:
            begin
                div_num = DIVN'(num_abs) << F;
                div_den = side_reg ? ry_abs : rx_abs;
            end
            S_LINE:
            begin
                div_num = DIVN'(height_reg) << F;
                div_den = dist_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        div_run_next = div_run_reg;
        done_next    = 1'b0;
        div_start    = 1'b0;
        col_next     = col_reg;
        cam_next     = cam_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        prod_next    = prod_reg;
        sdx_next     = sdx_reg;
        sdy_next     = sdy_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        side_next    = side_reg;
        err_next     = err_reg;
        dist_next    = dist_reg;
        lh_next      = lh_reg;
        res_next     = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd.opcode == OP_CAST))
                begin
                    col_next   = cmd.column;
                    err_next   = 1'b0;
                    side_next  = SIDE_X;
                    state_next = S_CAM;
                end
            end
            S_CAM:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    cam_next     = CAMW'(div_quo) - CAMW'(ONE_N);
                    state_next   = S_MULX;
                end
            end
            S_MULX:
            begin
                prod_next  = mul_p;
                state_next = S_RAYX;
            end
            S_RAYX:
            begin
                rx_next    = RW'(dirx_reg) + fix_trunc(prod_reg);
                state_next = S_MULY;
            end
            S_MULY:
            begin
                prod_next  = mul_p;
                state_next = S_RAYY;
            end
            S_RAYY:
            begin
                ry_next    = RW'(diry_reg) + fix_trunc(prod_reg);
                state_next = S_DELX;
            end
            S_DELX:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    dx_next      = (rx_reg == '0) ? SAT32 : sat32(div_quo);
                    state_next   = S_DELY;
                end
            end
            S_DELY:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    dy_next      = (ry_reg == '0) ? SAT32 : sat32(div_quo);
                    state_next   = S_SDX;
                end
            end
            S_SDX:
            begin
                prod_next  = mul_p;
                state_next = S_SDY;
            end
            S_SDY:
            begin
                sdx_next   = SDW'(prod_reg >>> F);
                prod_next  = mul_p;
                state_next = S_SEED;
            end
            S_SEED:
            begin
                sdy_next = SDW'(prod_reg >>> F);
                if (((eye_xw >> F) >= DIM_E) || ((eye_yw >> F) >= DIM_E))
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    mx_next    = PW'(eye_xw >> F);
                    my_next    = PW'(eye_yw >> F);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (x_first)
                begin
                    sdx_next  = sdx_reg + SDW'(dx_reg);
                    side_next = SIDE_X;
                end
                else
                begin
                    sdy_next  = sdy_reg + SDW'(dy_reg);
                    side_next = SIDE_Y;
                end
                mx_next = nx;
                my_next = ny;
                if (walk_out)
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = (ram_rdata > WALL_MARK) ? S_DIST : S_STEP;
            end
            S_DIST:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    dist_next    = (div_den == '0) ? SAT32 : sat32(div_quo);
                    state_next   = S_LINE;
                end
            end
            S_LINE:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    if ((dist_reg == '0) || (div_quo > SAT16_N))
                    begin
                        lh_next = SAT16;
                    end
                    else
                    begin
                        lh_next = div_quo[15:0];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_next             = '0;
                res_next.column_done = col_reg;
                if (err_reg)
                begin
                    res_next.status = ST_OUT;
                end
                else
                begin
                    res_next.status        = ST_HIT;
                    res_next.wall_side     = side_reg;
                    res_next.wall_distance = dist_reg;
                    res_next.line_height   = lh_reg;
                    res_next.draw_start    = st;
                    res_next.draw_end      = (en17 > 17'd4095) ? 12'd4095 : en17[11:0];
                    res_next.wall_color    = (side_reg == SIDE_Y) ? COLOR_Y : COLOR_X;
                    res_next.hit_x         = 6'(mx_reg);
                    res_next.hit_y         = 6'(my_reg);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_run_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_run_reg <= div_run_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        cam_reg  <= cam_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        sdx_reg  <= sdx_next;
        sdy_reg  <= sdy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        side_reg <= side_next;
        err_reg  <= err_next;
        dist_reg <= dist_next;
        lh_reg   <= lh_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

[rtl/core/ddarc_ram.sv]
module ddarc_ram
    import ddarc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = MAP_DIM_DEF * MAP_DIM_DEF
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/ddarc_div.sv]
module ddarc_div
    import ddarc_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(NUM_W);
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

[rtl/core/ddarc_checker.sv]
module ddarc_checker
    import ddarc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input item_t   cmd,
    input logic    busy,
    input logic    done,
    input result_t res
);

    // A cast beat keeps the block busy from the next cycle on.
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_CAST)) |=> busy)
        else $error("cast beat did not raise busy");

    // A write beat completes at once and produces no result.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_WRITE)) |=> (!busy && !done))
        else $error("write beat caused activity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res.status == ST_OUT)) |->
        ((res.wall_distance == '0) && (res.line_height == '0) && (res.wall_color == '0)))
        else $error("error result carries data");

    a_hit_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res.status == ST_HIT)) |->
        ((res.draw_start <= res.draw_end)
         && (res.wall_color == ((res.wall_side == SIDE_Y) ? COLOR_Y : COLOR_X))))
        else $error("hit result rows or color inconsistent");

endmodule

bind dda_ray_column_caster ddarc_checker u_ddarc_checker (.*);
